// File: hw/rtl/shw_pkg.sv
// Package for the session heartbeat watchdog.
// Holds the request and result types, event and status codes and the register map.
// No dependencies.
package shw_pkg;

  localparam int unsigned KindW  = 3;
  localparam int unsigned StampW = 64;
  localparam int unsigned LimitW = 32;
  localparam int unsigned MissW  = 9;
  localparam int unsigned MaxMissW = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [MissW-1:0] MissSat = 9'd511;

  localparam logic [LimitW-1:0]   RegisterWaitRst = 32'd10000;
  localparam logic [LimitW-1:0]   ReplyTimeoutRst = 32'd5000;
  localparam logic [MaxMissW-1:0] MaxMissesRst    = 8'd3;

  localparam logic [KindW-1:0] KIND_ATTACH   = 3'd0;
  localparam logic [KindW-1:0] KIND_REGISTER = 3'd1;
  localparam logic [KindW-1:0] KIND_HB_SENT  = 3'd2;
  localparam logic [KindW-1:0] KIND_REPLY    = 3'd3;
  localparam logic [KindW-1:0] KIND_CHECK    = 3'd4;

  localparam logic [CfgIdxW-1:0] CFG_REGISTER_WAIT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_REPLY_TIMEOUT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_MISSES    = 2'd2;

  typedef enum logic [2:0] {
    ST_UNREG   = 3'd0,
    ST_AWAIT   = 3'd1,
    ST_REPLIED = 3'd2,
    ST_TIMEOUT = 3'd3,
    ST_OFFLINE = 3'd4
  } status_e;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [StampW-1:0] now;
  } shw_in_t;

  typedef struct packed {
    logic             kick;
    logic [2:0]       status;
    logic             heartbeat_due;
    logic [MissW-1:0] misses;
  } shw_out_t;

  typedef struct packed {
    logic [LimitW-1:0]   register_wait;
    logic [LimitW-1:0]   reply_timeout;
    logic [MaxMissW-1:0] max_misses;
  } shw_cfg_t;

endpackage

// File: hw/rtl/shw_cfg_regs.sv
// Configuration registers of the session heartbeat watchdog.
// Decodes the register index of each write request; depends on shw_pkg.
module shw_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [shw_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [shw_pkg::CfgDataW-1:0]  cfg_data_i,
  output shw_pkg::shw_cfg_t             cfg_o
);
  import shw_pkg::*;

  shw_cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_REGISTER_WAIT: cfg_d.register_wait = cfg_data_i;
        CFG_REPLY_TIMEOUT: cfg_d.reply_timeout = cfg_data_i;
        CFG_MAX_MISSES:    cfg_d.max_misses    = cfg_data_i[MaxMissW-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.register_wait <= RegisterWaitRst;
      cfg_q.reply_timeout <= ReplyTimeoutRst;
      cfg_q.max_misses    <= MaxMissesRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/shw_session.sv
// Session state and event evaluation of the session heartbeat watchdog.
// Computes the result of one request and updates the state on step_i; depends on shw_pkg.
module shw_session (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  shw_pkg::shw_in_t   item_i,
  input  shw_pkg::shw_cfg_t  cfg_i,
  output shw_pkg::shw_out_t  res_o
);
  import shw_pkg::*;

  status_e           status_d, status_q;
  logic [StampW-1:0] attach_d, attach_q;
  logic [StampW-1:0] request_d, request_q;
  logic [MissW-1:0]  miss_d, miss_q;

  logic [StampW-1:0] stamp_sel;
  logic [LimitW-1:0] limit_sel;
  logic [StampW:0]   diff;
  logic              expired;
  logic [MissW-1:0]  miss_inc;
  logic              kick;

  assign stamp_sel = (status_q == ST_UNREG) ? attach_q : request_q;
  assign limit_sel = (status_q == ST_UNREG) ? cfg_i.register_wait : cfg_i.reply_timeout;
  assign diff      = {1'b0, item_i.now} - {1'b0, stamp_sel};
  assign expired   = !diff[StampW] &&
                     (diff[StampW-1:0] > {{(StampW-LimitW){1'b0}}, limit_sel});
  assign miss_inc  = (miss_q != MissSat) ? miss_q + 1'b1 : miss_q;

  always_comb begin
    status_d  = status_q;
    attach_d  = attach_q;
    request_d = request_q;
    miss_d    = miss_q;
    kick      = 1'b0;
    unique case (item_i.kind)
      KIND_ATTACH: begin
        attach_d = item_i.now;
        status_d = ST_UNREG;
        miss_d   = '0;
      end
      KIND_REGISTER, KIND_HB_SENT: begin
        status_d  = ST_AWAIT;
        request_d = item_i.now;
      end
      KIND_REPLY: begin
        if (status_q != ST_OFFLINE) begin
          status_d = ST_REPLIED;
          miss_d   = '0;
        end
      end
      KIND_CHECK: begin
        if (status_q == ST_UNREG && expired) begin
          status_d = ST_OFFLINE;
          kick     = 1'b1;
        end else if (status_q == ST_AWAIT && expired) begin
          miss_d = miss_inc;
          if (miss_inc > {1'b0, cfg_i.max_misses}) begin
            status_d = ST_OFFLINE;
            kick     = 1'b1;
          end else begin
            status_d = ST_TIMEOUT;
          end
        end
      end
      default: begin
        status_d = status_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q  <= ST_UNREG;
      attach_q  <= '0;
      request_q <= '0;
      miss_q    <= '0;
    end else if (step_i) begin
      status_q  <= status_d;
      attach_q  <= attach_d;
      request_q <= request_d;
      miss_q    <= miss_d;
    end
  end

  assign res_o.kick          = kick;
  assign res_o.status        = status_d;
  assign res_o.heartbeat_due = (status_d != ST_UNREG) && (status_d != ST_OFFLINE);
  assign res_o.misses        = miss_d;

`ifndef ASSERT_OFF
  a_miss_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |=> (miss_q == '0) || (miss_q == $past(miss_q)) ||
               (miss_q == $past(miss_q) + 1'b1))
    else $error("miss count moved by more than one");
  a_kick_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kick |-> (item_i.kind == KIND_CHECK) && expired)
    else $error("kick without an expired check");
  a_offline_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && status_q == ST_OFFLINE && item_i.kind == KIND_REPLY |=> status_q == ST_OFFLINE)
    else $error("reply left the offline status");
`endif

endmodule

// File: hw/rtl/session_heartbeat_watchdog.sv
// Top level of the session heartbeat watchdog.
// Input register, session evaluation and result register; depends on shw_pkg,
// shw_cfg_regs and shw_session.
//
// The watchdog accepts one event request per clock cycle while the input is ready, and
// returns exactly one result for each; the request is held in the input register and its
// result in the result register, with a single stage between them, a 64-bit
// subtract of the selected stamp from the event time and its compare against the
// selected limit. Back-pressure on the result side holds the input register. While a
// result waits, one more request can still be taken into an empty input register, and
// the input then stalls until the result is taken. Configuration writes are always
// accepted and take effect at the next cycle; there is no clearing pass after reset.
module session_heartbeat_watchdog (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  shw_pkg::shw_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output shw_pkg::shw_out_t             out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [shw_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [shw_pkg::CfgDataW-1:0]  cfg_data_i
);
  import shw_pkg::*;

  shw_cfg_t cfg;
  shw_in_t  in_data_q;
  logic     in_valid_d, in_valid_q;
  shw_out_t res;
  shw_out_t out_data_q;
  logic     out_valid_d, out_valid_q;
  logic     advance;
  logic     in_take;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  assign in_valid_d  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  shw_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  shw_session u_session (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_data_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef ASSERT_OFF
  a_kick_offline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kick |-> out_data_o.status == ST_OFFLINE)
    else $error("kick reported without offline status");
  a_due_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.heartbeat_due ==
      ((out_data_o.status != ST_UNREG) && (out_data_o.status != ST_OFFLINE)))
    else $error("heartbeat eligibility disagrees with status");
  a_held_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_data_q))
    else $error("stalled request lost from the input register");
`endif

endmodule
